// ----- rtl/core/tts_pkg.sv -----
// Shared types, constants and codes for the transposition table store/probe block.
// Used by the controller, the datapath and the top level.
package tts_pkg;

  localparam int INDEX_BITS = 16;
  localparam int SLOT_COUNT = 1 << INDEX_BITS;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MATE_HIGH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATE_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NULL_RED  = 2'd2;

  localparam logic signed [15:0] MATE_HIGH_RESET = 16'sd30000;
  localparam logic signed [15:0] MATE_LOW_RESET  = -16'sd30000;
  localparam logic [3:0]         NULL_RED_RESET  = 4'd3;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  localparam logic [1:0] BOUND_EXACT = 2'd3;

  localparam logic [2:0] ST_EMPTY      = 3'd0;
  localparam logic [2:0] ST_UPPER      = 3'd1;
  localparam logic [2:0] ST_LOWER      = 3'd2;
  localparam logic [2:0] ST_EXACT      = 3'd3;
  localparam logic [2:0] ST_AVOID_NULL = 3'd4;

  typedef struct packed {
    logic               opcode;
    logic [63:0]        position_key;
    logic [7:0]         search_depth;
    logic [7:0]         ply_from_root;
    logic signed [15:0] score_in;
    logic [1:0]         bound_kind;
    logic [31:0]        best_move;
    logic signed [15:0] alpha_bound;
    logic signed [15:0] beta_bound;
  } tts_req_t;

  typedef struct packed {
    logic [2:0]         probe_status;
    logic signed [15:0] probe_value;
    logic               key_hit;
    logic [31:0]        hit_move;
  } tts_rsp_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic [31:0]        move;
    logic [1:0]         bound;
  } tts_entry_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic finish;
  } tts_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_probe;
    logic out_blocked;
  } tts_sts_t;

endpackage

// ----- rtl/core/tts_req_if.sv -----
// Request channel carrying one store or probe item with a valid/ready handshake.
// Field widths follow the block's input item definition.
interface tts_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [63:0]        position_key;
  logic [7:0]         search_depth;
  logic [7:0]         ply_from_root;
  logic signed [15:0] score_in;
  logic [1:0]         bound_kind;
  logic [31:0]        best_move;
  logic signed [15:0] alpha_bound;
  logic signed [15:0] beta_bound;

  modport source(
    output valid, opcode, position_key, search_depth, ply_from_root, score_in,
    output bound_kind, best_move, alpha_bound, beta_bound,
    input  ready
  );
  modport sink(
    input  valid, opcode, position_key, search_depth, ply_from_root, score_in,
    input  bound_kind, best_move, alpha_bound, beta_bound,
    output ready
  );
endinterface

// ----- rtl/core/tts_rsp_if.sv -----
// Response channel carrying one probe result item with a valid/ready handshake.
// Field widths follow the block's result item definition.
interface tts_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         probe_status;
  logic signed [15:0] probe_value;
  logic               key_hit;
  logic [31:0]        hit_move;

  modport source(
    output valid, probe_status, probe_value, key_hit, hit_move,
    input  ready
  );
  modport sink(
    input  valid, probe_status, probe_value, key_hit, hit_move,
    output ready
  );
endinterface

// ----- rtl/core/tts_ctrl.sv -----
// Controller for the transposition table: clearing pass, item accept and lookup/commit.
// Depends on tts_pkg for the command and status structs.
module tts_ctrl
  import tts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  tts_sts_t sts,
  output tts_cmd_t cmd
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOKUP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.clear_en = 1'b0;
    cmd.accept   = 1'b0;
    cmd.finish   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!sts.is_probe || !sts.out_blocked) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/core/tts_dp.sv -----
// Datapath for the transposition table: slot memory, item register, mate score
// adjustment, probe evaluation, result register and configuration registers.
// Depends on tts_pkg for types, codes and table size.
module tts_dp
  import tts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  tts_cmd_t               cmd,
  output tts_sts_t               sts,
  input  tts_req_t               req_pl,
  input  logic                   rsp_ready,
  output logic                   rsp_valid,
  output tts_rsp_t               rsp_pl,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
    logic signed [15:0] r;
    if (x > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  tts_entry_t mem [SLOT_COUNT];

  logic signed [15:0]    mate_high;
  logic signed [15:0]    mate_low;
  logic [3:0]            null_red;
  logic [INDEX_BITS-1:0] clr_cnt;
  tts_req_t              item;
  tts_entry_t            rd_q;

  logic                  hit;
  logic                  skip;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  tts_entry_t            mem_wdata;
  logic signed [17:0]    ply18;
  logic signed [17:0]    in18;
  logic signed [17:0]    st18;
  logic signed [15:0]    store_score;
  logic signed [15:0]    probe_score;
  logic signed [9:0]     sd_s;
  logic signed [9:0]     lim_s;
  logic [2:0]            status;
  logic signed [15:0]    value;

  always_ff @(posedge clk) begin
    if (rst) begin
      mate_high <= MATE_HIGH_RESET;
      mate_low  <= MATE_LOW_RESET;
      null_red  <= NULL_RED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATE_HIGH: mate_high <= $signed(cfg_data);
        CFG_MATE_LOW:  mate_low  <= $signed(cfg_data);
        CFG_NULL_RED:  null_red  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= req_pl;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.accept) begin
      rd_q <= mem[req_pl.position_key[INDEX_BITS-1:0]];
    end
  end

  assign hit   = (rd_q.key == item.position_key);
  assign skip  = hit && (rd_q.depth > item.search_depth);
  assign ply18 = $signed({10'd0, item.ply_from_root});

  assign in18 = {{2{item.score_in[15]}}, item.score_in};
  always_comb begin
    store_score = item.score_in;
    if (item.score_in > mate_high || item.score_in < mate_low) begin
      store_score = sat16((item.score_in > 16'sd0) ? in18 + ply18 : in18 - ply18);
    end
  end

  assign st18 = {{2{rd_q.score[15]}}, rd_q.score};
  always_comb begin
    probe_score = rd_q.score;
    if (rd_q.score > mate_high || rd_q.score < mate_low) begin
      probe_score = sat16((rd_q.score > 16'sd0) ? st18 - ply18 : st18 + ply18);
    end
  end

  assign sd_s  = $signed({2'b00, rd_q.depth});
  assign lim_s = $signed({2'b00, item.search_depth}) - $signed({6'd0, null_red});

  always_comb begin
    status = ST_EMPTY;
    value  = '0;
    if (hit) begin
      if (sd_s >= lim_s && probe_score < item.beta_bound && rd_q.bound == BOUND_UPPER) begin
        status = ST_AVOID_NULL;
      end
      if (rd_q.depth > item.search_depth) begin
        if (rd_q.bound == BOUND_UPPER && probe_score <= item.alpha_bound) begin
          status = ST_UPPER;
          value  = item.alpha_bound;
        end else if (rd_q.bound == BOUND_LOWER && probe_score >= item.beta_bound) begin
          status = ST_LOWER;
          value  = item.beta_bound;
        end else if (rd_q.bound == BOUND_EXACT) begin
          status = ST_EXACT;
          value  = probe_score;
        end
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item.position_key[INDEX_BITS-1:0];
    mem_wdata = '{key: item.position_key, depth: item.search_depth, score: store_score,
                  move: item.best_move, bound: item.bound_kind};
    if (cmd.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (cmd.finish && item.opcode == OP_STORE && !skip) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish && item.opcode == OP_PROBE) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && item.opcode == OP_PROBE) begin
      rsp_pl.probe_status <= status;
      rsp_pl.probe_value  <= value;
      rsp_pl.key_hit      <= hit;
      rsp_pl.hit_move     <= hit ? rd_q.move : 32'd0;
    end
  end

  assign sts.clear_last  = &clr_cnt;
  assign sts.is_probe    = (item.opcode == OP_PROBE);
  assign sts.out_blocked = rsp_valid && !rsp_ready;

endmodule

// ----- rtl/core/transposition_table_store_probe_top.sv -----
// Direct-mapped, depth-preferred transposition table with store and probe items.
// For each item the slot is read from the single table memory in the
// accept cycle and written back or evaluated in the next; a probe also waits there
// while an earlier result is still held in the output register. After reset a
// clearing pass writes zero to every slot, one per cycle, all 2^INDEX_BITS of them
// (65536 at the default size); no item is accepted until it ends, while
// configuration writes are taken at any time.
module transposition_table_store_probe_top
  import tts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tts_req_if.sink                req,
  tts_rsp_if.source              rsp
);

  tts_cmd_t cmd;
  tts_sts_t sts;
  tts_req_t req_pl;
  tts_rsp_t rsp_pl;

  assign req_pl = '{opcode: req.opcode, position_key: req.position_key,
                    search_depth: req.search_depth, ply_from_root: req.ply_from_root,
                    score_in: req.score_in, bound_kind: req.bound_kind,
                    best_move: req.best_move, alpha_bound: req.alpha_bound,
                    beta_bound: req.beta_bound};

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_pl    (req_pl),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp_pl    (rsp_pl),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  assign rsp.probe_status = rsp_pl.probe_status;
  assign rsp.probe_value  = rsp_pl.probe_value;
  assign rsp.key_hit      = rsp_pl.key_hit;
  assign rsp.hit_move     = rsp_pl.hit_move;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clear_en && req.ready))
    else $error("Item handshake open during the clearing pass.");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("Second item accepted while a lookup is pending.");

  a_lookup_progress: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (cmd.finish || sts.out_blocked))
    else $error("Lookup stalled without a blocked output.");

  a_result_from_probe: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.finish && sts.is_probe))
    else $error("Result item appeared without a finished probe.");

endmodule

// ----- tb/tts_table_monitor.sv -----
// Passive monitor for the transposition table: mirrors the slot table and the
// mate/null-move registers, predicts every probe answer and compares results.
// Depends on tts_pkg and the tts_req_if / tts_rsp_if channel interfaces.
module tts_table_monitor
  import tts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tts_req_if                     req,
  tts_rsp_if                     rsp,
  output int                     fail_count,
  output int                     probes_pending,
  output int                     store_count,
  output int                     probe_count,
  output int                     hit_count,
  output int                     cutoff_count,
  output int                     avoid_null_count
);
  timeunit 1ns;
  timeprecision 1ps;

  tts_entry_t         slot_table [logic [INDEX_BITS-1:0]];
  tts_rsp_t           probe_answers [$];
  logic signed [15:0] mate_high;
  logic signed [15:0] mate_low;
  logic [3:0]         null_red;
  tts_req_t           seen_item;
  tts_rsp_t           seen_result;
  int                 fails;
  int                 stores;
  int                 probes;
  int                 hits;
  int                 cutoffs;
  int                 avoids;

  function automatic logic signed [15:0] clamp_score(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic bit is_mate_score(int v);
    return v > int'(mate_high) || v < int'(mate_low);
  endfunction

  function automatic void apply_item(tts_req_t it);
    logic [INDEX_BITS-1:0] slot;
    tts_entry_t            ent;
    tts_rsp_t              ans;
    logic                  hit;
    int                    v;
    int                    ply;
    int                    depth;
    int                    alpha;
    int                    beta;
    slot  = it.position_key[INDEX_BITS-1:0];
    ply   = it.ply_from_root;
    depth = it.search_depth;
    alpha = it.alpha_bound;
    beta  = it.beta_bound;
    if (slot_table.exists(slot)) begin
      ent = slot_table[slot];
    end else begin
      ent = '0;
    end
    hit = (ent.key == it.position_key);
    if (it.opcode == OP_STORE) begin
      stores++;
      if (hit && ent.depth > it.search_depth) return;
      v = it.score_in;
      if (is_mate_score(v)) v = clamp_score(v > 0 ? v + ply : v - ply);
      ent.key   = it.position_key;
      ent.depth = it.search_depth;
      ent.score = v[15:0];
      ent.move  = it.best_move;
      ent.bound = it.bound_kind;
      slot_table[slot] = ent;
      return;
    end
    probes++;
    ans = '0;
    if (hit) begin
      hits++;
      ans.key_hit  = 1'b1;
      ans.hit_move = ent.move;
      v = ent.score;
      if (is_mate_score(v)) v = clamp_score(v > 0 ? v - ply : v + ply);
      if (int'(ent.depth) >= depth - int'(null_red) && v < beta &&
          ent.bound == BOUND_UPPER) begin
        ans.probe_status = ST_AVOID_NULL;
      end
      if (ent.depth > it.search_depth) begin
        if (ent.bound == BOUND_UPPER && v <= alpha) begin
          ans.probe_status = ST_UPPER;
          ans.probe_value  = alpha[15:0];
        end else if (ent.bound == BOUND_LOWER && v >= beta) begin
          ans.probe_status = ST_LOWER;
          ans.probe_value  = beta[15:0];
        end else if (ent.bound == BOUND_EXACT) begin
          ans.probe_status = ST_EXACT;
          ans.probe_value  = v[15:0];
        end
      end
    end
    if (ans.probe_status == ST_AVOID_NULL) avoids++;
    else if (ans.probe_status != ST_EMPTY) cutoffs++;
    probe_answers.push_back(ans);
  endfunction

  function automatic void note_mismatch(string field, longint want, longint got);
    fails++;
    $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  function automatic void check_result(tts_rsp_t got);
    tts_rsp_t want;
    if (probe_answers.size() == 0) begin
      fails++;
      $display("%0t ns: result with no probe outstanding (status %0d value %0d hit %0d)",
               $time, got.probe_status, got.probe_value, got.key_hit);
      return;
    end
    want = probe_answers.pop_front();
    if (got.probe_status !== want.probe_status)
      note_mismatch("probe_status", want.probe_status, got.probe_status);
    if (got.probe_value !== want.probe_value)
      note_mismatch("probe_value", want.probe_value, got.probe_value);
    if (got.key_hit !== want.key_hit)
      note_mismatch("key_hit", want.key_hit, got.key_hit);
    if (got.hit_move !== want.hit_move)
      note_mismatch("hit_move", want.hit_move, got.hit_move);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      slot_table.delete();
      probe_answers.delete();
      mate_high = MATE_HIGH_RESET;
      mate_low  = MATE_LOW_RESET;
      null_red  = NULL_RED_RESET;
      fails   = 0;
      stores  = 0;
      probes  = 0;
      hits    = 0;
      cutoffs = 0;
      avoids  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATE_HIGH: mate_high = cfg_data;
          CFG_MATE_LOW:  mate_low  = cfg_data;
          CFG_NULL_RED:  null_red  = cfg_data[3:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        seen_item = {req.opcode, req.position_key, req.search_depth, req.ply_from_root,
                     req.score_in, req.bound_kind, req.best_move, req.alpha_bound,
                     req.beta_bound};
        apply_item(seen_item);
      end
      if (rsp.valid && rsp.ready) begin
        seen_result = {rsp.probe_status, rsp.probe_value, rsp.key_hit, rsp.hit_move};
        check_result(seen_result);
      end
    end
    fail_count       <= fails;
    probes_pending   <= probe_answers.size();
    store_count      <= stores;
    probe_count      <= probes;
    hit_count        <= hits;
    cutoff_count     <= cutoffs;
    avoid_null_count <= avoids;
  end

endmodule

// ----- tb/transposition_table_store_probe_top_tb.sv -----
// Top of the transposition table testbench: clock, reset, register writes and
// store/probe stimulus with random stalls; tts_table_monitor does the checking.
// Depends on tts_pkg, the channel interfaces and transposition_table_store_probe_top.
module transposition_table_store_probe_top_tb import tts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 220;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int probes_pending;
  int store_count;
  int probe_count;
  int hit_count;
  int cutoff_count;
  int avoid_null_count;

  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 hold_requests;
  logic signed [15:0] cur_hi;
  logic signed [15:0] cur_lo;
  logic [63:0]        key_pool [24];
  logic [15:0]        slot_pick [8];

  tts_req_if req();
  tts_rsp_if rsp();

  transposition_table_store_probe_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  tts_table_monitor table_mon (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req              (req),
    .rsp              (rsp),
    .fail_count       (fail_count),
    .probes_pending   (probes_pending),
    .store_count      (store_count),
    .probe_count      (probe_count),
    .hit_count        (hit_count),
    .cutoff_count     (cutoff_count),
    .avoid_null_count (avoid_null_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic tts_req_t item_of(logic op, logic [63:0] key, int depth, int ply,
                                       int score, logic [1:0] bound, logic [31:0] mv,
                                       int alpha, int beta);
    tts_req_t it;
    it.opcode        = op;
    it.position_key  = key;
    it.search_depth  = depth[7:0];
    it.ply_from_root = ply[7:0];
    it.score_in      = score[15:0];
    it.bound_kind    = bound;
    it.best_move     = mv;
    it.alpha_bound   = alpha[15:0];
    it.beta_bound    = beta[15:0];
    return it;
  endfunction

  function automatic logic signed [15:0] pick_score();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 40) v = $urandom_range(400) - 200;
    else if (r < 55) v = $urandom_range(32767, 29500);
    else if (r < 70) v = -int'($urandom_range(32768, 29500));
    else if (r < 78) v = int'(cur_hi) + $urandom_range(20) - 10;
    else if (r < 86) v = int'(cur_lo) + $urandom_range(20) - 10;
    else v = $urandom;
    return v[15:0];
  endfunction

  task automatic put_item(tts_req_t it);
    {req.opcode, req.position_key, req.search_depth, req.ply_from_root, req.score_in,
     req.bound_kind, req.best_move, req.alpha_bound, req.beta_bound} <= it;
  endtask

  task automatic send_item(tts_req_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req.valid <= 1'b1;
    put_item(it);
    do @(posedge clk); while (req.ready !== 1'b1);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (probes_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_registers(logic signed [15:0] hi, logic signed [15:0] lo,
                               logic [3:0] red);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MATE_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= CFG_MATE_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_NULL_RED;
    cfg_data  <= {12'd0, red};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_hi = hi;
    cur_lo = lo;
  endtask

  initial begin
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("No item moved on either channel for %0d cycles.", QUIET_LIMIT);
    $display("transposition_table_store_probe_top: mismatch");
    $finish;
  end

  initial begin
    tts_req_t    it;
    logic [63:0] k1;
    int          phase;
    int          n;
    int          mode;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_MATE_HIGH;
    cfg_data      <= '0;
    req.valid     <= 1'b0;
    put_item(tts_req_t'(0));
    rx_idle_pct   <= 0;
    hold_requests <= 0;
    tx_idle_pct = 0;
    cur_hi = MATE_HIGH_RESET;
    cur_lo = MATE_LOW_RESET;
    slot_pick[0] = 16'h0000;
    slot_pick[1] = 16'hffff;
    for (int i = 2; i < 8; i++) slot_pick[i] = 16'($urandom);
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, 16'($urandom), slot_pick[i / 3]};
    key_pool[0] = '0;
    k1 = 64'h0123_4567_89ab_0011;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed items run with the registers at their reset values.
    send_item(item_of(OP_PROBE, 64'h0, 0, 0, 0, 2'd0, 32'h0, 0, 0));
    send_item(item_of(OP_PROBE, '1, 255, 255, 0, 2'd0, 32'h0, -32768, 32767));
    send_item(item_of(OP_STORE, k1, 5, 0, 100, BOUND_UPPER, 32'h1234_5678, 0, 0));
    send_item(item_of(OP_PROBE, k1, 3, 0, 0, 2'd0, 32'h0, 150, 300));
    send_item(item_of(OP_STORE, k1, 2, 0, -5, BOUND_EXACT, 32'h1, 0, 0));
    send_item(item_of(OP_PROBE, k1, 0, 0, 0, 2'd0, 32'h0, 50, 60));
    send_item(item_of(OP_STORE, k1, 5, 0, -5, BOUND_EXACT, 32'hffff_ffff, 0, 0));
    send_item(item_of(OP_PROBE, k1, 4, 0, 0, 2'd0, 32'h0, -100, 100));
    send_item(item_of(OP_STORE, k1 ^ 64'h1_0000, 0, 0, 77, BOUND_LOWER, 32'h2, 0, 0));
    send_item(item_of(OP_PROBE, k1, 0, 0, 0, 2'd0, 32'h0, 0, 0));
    send_item(item_of(OP_PROBE, k1 ^ 64'h1_0000, 0, 0, 0, 2'd0, 32'h0, 0, 0));
    send_item(item_of(OP_STORE, 64'h8000_0000_0000_0022, 10, 0, 50, BOUND_LOWER,
                      32'h22, 0, 0));
    send_item(item_of(OP_PROBE, 64'h8000_0000_0000_0022, 2, 0, 0, 2'd0, 32'h0, 0, 40));
    send_item(item_of(OP_PROBE, 64'h8000_0000_0000_0022, 2, 0, 0, 2'd0, 32'h0, 0, -32768));
    send_item(item_of(OP_STORE, 64'h7fff_ffff_ffff_0033, 3, 10, 32000, BOUND_EXACT,
                      32'h33, 0, 0));
    send_item(item_of(OP_PROBE, 64'h7fff_ffff_ffff_0033, 0, 20, 0, 2'd0, 32'h0, 0, 0));
    send_item(item_of(OP_STORE, 64'h44, 1, 255, 32760, BOUND_EXACT, 32'h44, 0, 0));
    send_item(item_of(OP_PROBE, 64'h44, 0, 0, 0, 2'd0, 32'h0, 0, 0));
    send_item(item_of(OP_STORE, 64'h55, 1, 200, -32768, BOUND_EXACT, 32'h55, 0, 0));
    send_item(item_of(OP_PROBE, 64'h55, 0, 255, 0, 2'd0, 32'h0, 0, 0));
    send_item(item_of(OP_STORE, 64'h66, 1, 0, -50, BOUND_UPPER, 32'h66, 0, 0));
    send_item(item_of(OP_PROBE, 64'h66, 4, 0, 0, 2'd0, 32'h0, -100, 0));
    send_item(item_of(OP_PROBE, 64'h66, 0, 0, 0, 2'd0, 32'h0, -100, 0));
    send_item(item_of(OP_STORE, 64'h77, 0, 0, 10, BOUND_UPPER, 32'h77, 0, 0));
    send_item(item_of(OP_PROBE, 64'h77, 2, 0, 0, 2'd0, 32'h0, -100, 20));
    send_item(item_of(OP_STORE, 64'h88, 9, 0, 5, 2'd0, 32'h88, 0, 0));
    send_item(item_of(OP_PROBE, 64'h88, 0, 0, 0, 2'd0, 32'h0, 100, -100));
    send_item(item_of(OP_STORE, '1, 255, 255, 32767, BOUND_EXACT, 32'hffff_ffff, 0, 0));
    send_item(item_of(OP_PROBE, '1, 255, 255, 0, 2'd0, 32'h0, -32768, 32767));
    send_item(item_of(OP_PROBE, '1, 0, 255, 0, 2'd0, 32'h0, -32768, 32767));

    for (phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: set_registers(MATE_HIGH_RESET, MATE_LOW_RESET, NULL_RED_RESET);
        1: set_registers(16'sh7fff, 16'sh8000, 4'd0);
        2: set_registers(16'sh8000, 16'sh7fff, 4'd15);
        3: set_registers(16'sh0000, 16'sh0000, 4'd7);
        4: set_registers(16'($urandom_range(32000, 20000)),
                         -16'($urandom_range(32000, 20000)), 4'($urandom));
        default: set_registers(16'sd100, -16'sd100, 4'd1);
      endcase
      mode = phase % 3;
      tx_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 61 : 0;
      rx_idle_pct <= (mode == 0) ? 61 : (mode == 1) ? 20 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 40) hold_requests <= hold_requests + 1;
        if (phase == 4 && n == 110) drain();
        it.opcode = $urandom_range(1) ? OP_PROBE : OP_STORE;
        it.position_key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(23)]
                                                    : {$urandom, $urandom};
        case ($urandom_range(9))
          0: it.search_depth = $urandom_range(1) ? 8'd255 : 8'd0;
          1: it.search_depth = 8'($urandom);
          default: it.search_depth = 8'($urandom_range(12));
        endcase
        it.ply_from_root = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
        it.score_in    = pick_score();
        it.bound_kind  = 2'($urandom);
        it.best_move   = $urandom;
        it.alpha_bound = pick_score();
        it.beta_bound  = pick_score();
        send_item(it);
      end
    end
    drain();

    $display("Run covered %0d stores and %0d probes with %0d key hits, %0d cutoffs",
             store_count, probe_count, hit_count, cutoff_count);
    $display("and %0d avoid-null hints across six register settings and three stall mixes.",
             avoid_null_count);
    if (fail_count == 0 && probes_pending == 0) begin
      $display("transposition_table_store_probe_top: match");
    end else begin
      $display("transposition_table_store_probe_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tts_pkg.sv
rtl/core/tts_req_if.sv
rtl/core/tts_rsp_if.sv
rtl/core/tts_ctrl.sv
rtl/core/tts_dp.sv
rtl/core/transposition_table_store_probe_top.sv
tb/tts_table_monitor.sv
tb/transposition_table_store_probe_top_tb.sv
